// ===== src/scfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfc_pkg
// Shared types, byte positions and the CRC-16 byte update for the sensor
// reply frame checker.
// ----------------------------------------------------------------------------
package scfc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [2:0] IDX_FIRST   = 3'd0;
  localparam logic [2:0] IDX_HUM_HI  = 3'd2;
  localparam logic [2:0] IDX_HUM_LO  = 3'd3;
  localparam logic [2:0] IDX_TEMP_HI = 3'd4;
  localparam logic [2:0] IDX_TEMP_LO = 3'd5;
  localparam logic [2:0] IDX_CRC_LO  = 3'd6;
  localparam logic [2:0] IDX_CRC_HI  = 3'd7;

  // floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
  localparam logic [15:0] DIV10_RECIP = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic        crc_ok;
    logic [15:0] temperature_raw;
    logic [12:0] humidity_percent;
  } out_t;

  typedef struct packed {
    logic        fire;
    logic        crc_match;
    logic [15:0] humidity_word;
    logic [15:0] temperature_word;
  } frame_end_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== src/sensor_frame_crc_check_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_crc_check_decode
// Checks the CRC-16 of an 8-byte humidity and temperature sensor reply and
// returns the match flag, raw temperature and humidity/10, zero on mismatch.
//
//   channel  direction  payload  handshake
//   in       input      in_t     in_valid_i / in_stall_o
//   out      output     out_t    out_valid_o / out_stall_i
//
// One byte is taken per cycle; the eighth byte of a frame yields a result in
// the output register on the next cycle. Reset restarts the byte count and
// the CRC. The input stalls only while a result is held and the output is
// stalled; otherwise a byte is taken every cycle.
// ----------------------------------------------------------------------------
module sensor_frame_crc_check_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  scfc_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output scfc_pkg::out_t  out_data_o
);
  import scfc_pkg::*;

  logic       take;
  frame_end_t frame_end;

  assign in_stall_o = out_valid_o && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;

  scfc_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .in_data_i   (in_data_i),
    .frame_end_o (frame_end)
  );

  scfc_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_end_i (frame_end),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/scfc_frame.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfc_frame
// Byte position tracking, running CRC and field capture for one reply frame;
// flags the last byte together with the CRC comparison.
// ----------------------------------------------------------------------------
module scfc_frame (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    take_i,
  input  scfc_pkg::in_t           in_data_i,
  output scfc_pkg::frame_end_t    frame_end_o
);
  import scfc_pkg::*;

  logic [2:0]  idx_q, idx_d, idx_cur;
  logic [15:0] crc_q, crc_d, crc_base;
  logic [15:0] hum_q, hum_d;
  logic [15:0] temp_q, temp_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [7:0]  b;

  assign b        = in_data_i.rx_byte;
  assign idx_cur  = in_data_i.frame_start ? IDX_FIRST : idx_q;
  assign crc_base = in_data_i.frame_start ? CRC_INIT : crc_q;

  always_comb begin
    idx_d    = idx_q;
    crc_d    = crc_q;
    hum_d    = hum_q;
    temp_d   = temp_q;
    crc_lo_d = crc_lo_q;
    if (take_i) begin
      idx_d = idx_cur + 3'd1;
      if (idx_cur <= IDX_TEMP_LO) begin
        crc_d = crc_byte(crc_base, b);
      end else begin
        crc_d = crc_base;
      end
      case (idx_cur)
        IDX_HUM_HI:  hum_d    = {b, hum_q[7:0]};
        IDX_HUM_LO:  hum_d    = {hum_q[15:8], b};
        IDX_TEMP_HI: temp_d   = {b, temp_q[7:0]};
        IDX_TEMP_LO: temp_d   = {temp_q[15:8], b};
        IDX_CRC_LO:  crc_lo_d = b;
        IDX_CRC_HI: begin
          idx_d = IDX_FIRST;
          crc_d = CRC_INIT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= IDX_FIRST;
      crc_q    <= CRC_INIT;
      hum_q    <= '0;
      temp_q   <= '0;
      crc_lo_q <= '0;
    end else begin
      idx_q    <= idx_d;
      crc_q    <= crc_d;
      hum_q    <= hum_d;
      temp_q   <= temp_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  assign frame_end_o.fire             = take_i && (idx_cur == IDX_CRC_HI);
  assign frame_end_o.crc_match        = ({b, crc_lo_q} == crc_base);
  assign frame_end_o.humidity_word    = hum_q;
  assign frame_end_o.temperature_word = temp_q;

endmodule

// ===== src/scfc_result.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfc_result
// Humidity scaling by ten, mismatch zeroing and the output register.
// ----------------------------------------------------------------------------
module scfc_result (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  scfc_pkg::frame_end_t    frame_end_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output scfc_pkg::out_t          out_data_o
);
  import scfc_pkg::*;

  logic        valid_q, valid_d;
  out_t        data_q, data_d;
  logic [31:0] prod;

  assign prod = {16'h0000, frame_end_i.humidity_word} * {16'h0000, DIV10_RECIP};

  always_comb begin
    valid_d = valid_q && out_stall_i;
    data_d  = data_q;
    if (frame_end_i.fire) begin
      valid_d             = 1'b1;
      data_d.crc_ok       = frame_end_i.crc_match;
      data_d.temperature_raw = frame_end_i.crc_match ? frame_end_i.temperature_word : 16'h0000;
      data_d.humidity_percent = frame_end_i.crc_match ? prod[DIV10_SHIFT +: 13] : 13'h0000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensor reply frame checker. Reply bytes are
// queued as whole frames with good and corrupted CRCs, abandoned partial
// frames and loose bytes, then fed through a valid/stall driver with random
// idle gaps while the result side stalls at random. A byte-level decoder in
// the bench predicts each result, which is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import scfc_pkg::*;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  in_t  byte_queue[$];
  out_t expected_readings[$];

  logic [15:0] crc_run   = CRC_INIT;
  logic [2:0]  byte_pos  = IDX_FIRST;
  logic [15:0] hum_word  = '0;
  logic [15:0] temp_word = '0;
  logic [7:0]  crc_lo    = '0;

  int errors = 0;
  int idle_left, calm_left, stall_left, open_left;

  sensor_frame_crc_check_decode DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [15:0] crc16_shift(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] acc;
    logic        fb;
    acc = c;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ d[i];
      acc = {1'b0, acc[15:1]};
      if (fb) begin
        acc = acc ^ 16'hA001;
      end
    end
    return acc;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic decode_byte(input in_t item);
    out_t        r;
    logic [2:0]  pos;
    logic [15:0] rx_crc;
    logic        ok;
    if (item.frame_start) begin
      byte_pos = IDX_FIRST;
      crc_run  = CRC_INIT;
    end
    pos = byte_pos;
    if (pos <= IDX_TEMP_LO) begin
      crc_run = crc16_shift(crc_run, item.rx_byte);
    end
    case (pos)
      IDX_HUM_HI:  hum_word[15:8]  = item.rx_byte;
      IDX_HUM_LO:  hum_word[7:0]   = item.rx_byte;
      IDX_TEMP_HI: temp_word[15:8] = item.rx_byte;
      IDX_TEMP_LO: temp_word[7:0]  = item.rx_byte;
      IDX_CRC_LO:  crc_lo          = item.rx_byte;
      default: ;
    endcase
    if (pos == IDX_CRC_HI) begin
      rx_crc             = {item.rx_byte, crc_lo};
      ok                 = (rx_crc == crc_run);
      r.crc_ok           = ok;
      r.temperature_raw  = ok ? temp_word : 16'd0;
      r.humidity_percent = ok ? 13'(hum_word / 16'd10) : 13'd0;
      expected_readings.push_back(r);
      byte_pos = IDX_FIRST;
      crc_run  = CRC_INIT;
    end else begin
      byte_pos = pos + 3'd1;
    end
  endtask

  task automatic check_reading(input out_t got);
    out_t want;
    if (expected_readings.size() == 0) begin
      flag_mismatch($sformatf("unexpected result %h", got));
    end else begin
      want = expected_readings.pop_front();
      if (got.crc_ok !== want.crc_ok) begin
        flag_mismatch($sformatf("crc_ok got %b want %b", got.crc_ok, want.crc_ok));
      end
      if (got.temperature_raw !== want.temperature_raw) begin
        flag_mismatch($sformatf("temperature_raw got %h want %h",
                                got.temperature_raw, want.temperature_raw));
      end
      if (got.humidity_percent !== want.humidity_percent) begin
        flag_mismatch($sformatf("humidity_percent got %0d want %0d",
                                got.humidity_percent, want.humidity_percent));
      end
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic start);
    in_t item;
    item.rx_byte     = b;
    item.frame_start = start;
    byte_queue.push_back(item);
  endtask

  task automatic queue_frame(input logic start, input logic corrupt, input logic [7:0] b0,
                             input logic [7:0] b1, input logic [15:0] hum,
                             input logic [15:0] temp);
    logic [7:0]  fb[8];
    logic [15:0] c;
    int          flip;
    fb[0] = b0;
    fb[1] = b1;
    fb[2] = hum[15:8];
    fb[3] = hum[7:0];
    fb[4] = temp[15:8];
    fb[5] = temp[7:0];
    c = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      c = crc16_shift(c, fb[i]);
    end
    fb[6] = c[7:0];
    fb[7] = c[15:8];
    if (corrupt) begin
      flip = $urandom_range(0, 63);
      fb[flip / 8][flip % 8] = ~fb[flip / 8][flip % 8];
    end
    for (int i = 0; i < 8; i++) begin
      queue_byte(fb[i], (i == 0) ? start : 1'b0);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : feed_bytes
    int g;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      idle_left <= 0;
      calm_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (idle_left != 0) begin
        in_valid  <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (byte_queue.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= byte_queue.pop_front();
        if (calm_left != 0) begin
          g = 0;
          calm_left <= calm_left - 1;
        end else begin
          g = pick_gap();
          if ($urandom_range(0, 149) == 0) begin
            calm_left <= $urandom_range(20, 80);
          end
        end
        idle_left <= g;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : hold_results
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      open_left  <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (open_left != 0) begin
      out_stall <= 1'b0;
      open_left <= open_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 199) == 0) begin
        open_left <= $urandom_range(20, 80);
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : watch
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        check_reading(out_data);
      end
      if (in_valid && !in_stall) begin
        decode_byte(in_data);
      end
    end
  end

  initial begin : run
    int  r;
    int  n;
    logic need_start;
    // extremes, back-to-back frames, an abandoned partial frame, a bad CRC
    queue_frame(1'b1, 1'b0, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    queue_frame(1'b0, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000);
    queue_byte(8'h03, 1'b1);
    queue_byte(8'h04, 1'b0);
    queue_byte(8'h5A, 1'b0);
    queue_frame(1'b1, 1'b1, 8'h03, 8'h04, 16'h1234, 16'h8001);

    need_start = 1'b0;
    while (byte_queue.size() < 1450) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        queue_frame(need_start | 1'($urandom_range(0, 1)), 1'b0, 8'($urandom),
                    8'($urandom), 16'($urandom), 16'($urandom));
        need_start = 1'b0;
      end else if (r < 75) begin
        queue_frame(need_start | 1'($urandom_range(0, 1)), 1'b1, 8'($urandom),
                    8'($urandom), 16'($urandom), 16'($urandom));
        need_start = 1'b0;
      end else if (r < 85) begin
        n = $urandom_range(1, 7);
        for (int i = 0; i < n; i++) begin
          queue_byte(8'($urandom), i == 0);
        end
        need_start = 1'b1;
      end else if (r < 93) begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          queue_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end
        need_start = 1'b1;
      end else begin
        queue_frame(1'b1, 1'b0, 8'($urandom), 8'($urandom),
                    $urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                    $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
        need_start = 1'b0;
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_queue.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
